// File: sv/usd_pkg.sv
// shared constants, types and decode helpers for the utf-8 stream decoder
// no dependencies; imported by the interfaces and every module of the block
`default_nettype none

package usd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CP_W      = 21;
   localparam int unsigned LEN_W     = 3;
   localparam int unsigned CNT_W     = 3;
   localparam int unsigned BUF_DEPTH = 4;
   localparam int unsigned IDX_W     = 2;

   localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

   localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
   localparam logic [BYTE_W-1:0] TRAIL_MASK  = 8'hC0;
   localparam logic [BYTE_W-1:0] TRAIL_CODE  = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;

   localparam logic [CP_W-1:0] MIN_CP2   = 21'h000080;
   localparam logic [CP_W-1:0] MIN_CP3   = 21'h000800;
   localparam logic [CP_W-1:0] MIN_CP4   = 21'h010000;
   localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LOW  = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HIGH = 21'h00DFFF;

   localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
   localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
   localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
   localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CP_W-1:0]   cp_type;
   typedef logic [LEN_W-1:0]  len_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // append the accepted beat to the buffer
      logic step;   // register one result and drop the bytes it used
   } usd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic emit;      // head of buffer yields a result now
      logic last;      // that result ends the run for this beat
      logic out_free;  // output register can take a result
   } usd_status_type;

   function automatic len_type seq_length(input byte_type lead);
      len_type len;
      len = LEN_1;
      priority if (lead < ASCII_LIMIT)                 len = LEN_1;
      else if ((lead & LEAD2_MASK) == LEAD2_CODE)      len = LEN_2;
      else if ((lead & LEAD3_MASK) == LEAD3_CODE)      len = LEN_3;
      else if ((lead & LEAD4_MASK) == LEAD4_CODE)      len = LEN_4;
      else                                             len = LEN_1;
      return len;
   endfunction

   function automatic logic is_trail(input byte_type b);
      return (b & TRAIL_MASK) == TRAIL_CODE;
   endfunction

endpackage

`default_nettype wire

// File: sv/usd_if.sv
// valid/ready channel interfaces for the utf-8 stream decoder
// depends on usd_pkg
`default_nettype none

interface usd_req_if import usd_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface usd_rsp_if import usd_pkg::*; ();
   logic   valid;
   logic   ready;
   cp_type code_point;
   logic   replaced;
   logic   last_of_run;
   logic   text_end;

   modport source (output valid, output code_point, output replaced,
                   output last_of_run, output text_end, input ready);
   modport sink   (input valid, input code_point, input replaced,
                   input last_of_run, input text_end, output ready);
endinterface

`default_nettype wire

// File: sv/usd_datapath.sv
// byte buffer, sequence decode and output register of the utf-8 decoder
// depends on usd_pkg; driven by usd_ctrl through usd_cmd_type
`default_nettype none

module usd_datapath import usd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire usd_cmd_type    cmd,
   output usd_status_type      status,
   input  wire byte_type       in_byte,
   input  wire logic           in_end,
   output logic                out_valid,
   input  wire logic           out_ready,
   output cp_type              out_code_point,
   output logic                out_replaced,
   output logic                out_last_of_run,
   output logic                out_text_end
);

   byte_type buf_ff [BUF_DEPTH];
   byte_type buf_in [BUF_DEPTH];
   cnt_type  count_ff, count_in;
   logic     flush_ff, flush_in;
   logic     valid_ff, valid_in;
   cp_type   cp_ff, cp_in;
   logic     repl_ff, repl_in;
   logic     last_ff, last_in;
   logic     tend_ff, tend_in;

   byte_type head, b1, b2, b3, next_head;
   len_type  len, used;
   logic     enough, ok;
   cp_type   v2, v3, v4, value;
   cnt_type  rem;
   cnt_type  src;

   assign head = buf_ff[0];
   assign b1   = buf_ff[1];
   assign b2   = buf_ff[2];
   assign b3   = buf_ff[3];

   assign v2 = {10'd0, head[4:0], b1[5:0]};
   assign v3 = {5'd0, head[3:0], b1[5:0], b2[5:0]};
   assign v4 = {head[2:0], b1[5:0], b2[5:0], b3[5:0]};

   always_comb begin
      len    = seq_length(head);
      enough = count_ff >= cnt_type'(len);
      ok     = 1'b0;
      value  = {13'd0, head};
      unique case (len)
         LEN_1: begin
            ok    = head < ASCII_LIMIT;
            value = {13'd0, head};
         end
         LEN_2: begin
            ok    = is_trail(b1) && v2 >= MIN_CP2;
            value = v2;
         end
         LEN_3: begin
            ok    = is_trail(b1) && is_trail(b2) && v3 >= MIN_CP3
                    && !(v3 >= SURR_LOW && v3 <= SURR_HIGH);
            value = v3;
         end
         LEN_4: begin
            ok    = is_trail(b1) && is_trail(b2) && is_trail(b3)
                    && v4 >= MIN_CP4 && v4 <= MAX_CP;
            value = v4;
         end
         default: begin
            ok    = 1'b0;
            value = {13'd0, head};
         end
      endcase
      ok   = ok && enough;
      used = ok ? len : LEN_1;
      rem  = count_ff - cnt_type'(used);

      unique case (used)
         LEN_1:   next_head = b1;
         LEN_2:   next_head = b2;
         LEN_3:   next_head = b3;
         default: next_head = head;
      endcase
   end

   assign status.emit     = (count_ff != '0) && (enough || flush_ff);
   assign status.last     = !((rem != '0) && (flush_ff || rem >= cnt_type'(seq_length(next_head))));
   assign status.out_free = !valid_ff || out_ready;

   // buffer and count update
   always_comb begin
      for (int i = 0; i < BUF_DEPTH; i++) buf_in[i] = buf_ff[i];
      count_in = count_ff;
      flush_in = flush_ff;
      src      = '0;
      if (cmd.load) begin
         buf_in[count_ff[IDX_W-1:0]] = in_byte;
         count_in = count_ff + cnt_type'(1);
         flush_in = in_end;
      end else if (cmd.step) begin
         for (int i = 0; i < BUF_DEPTH; i++) begin
            src = cnt_type'(i) + cnt_type'(used);
            if (src < cnt_type'(BUF_DEPTH)) buf_in[i] = buf_ff[src[IDX_W-1:0]];
         end
         count_in = rem;
      end
   end

   // output register
   always_comb begin
      valid_in = valid_ff && !out_ready;
      cp_in    = cp_ff;
      repl_in  = repl_ff;
      last_in  = last_ff;
      tend_in  = tend_ff;
      if (cmd.step) begin
         valid_in = 1'b1;
         cp_in    = ok ? value : REPL_CP;
         repl_in  = !ok;
         last_in  = status.last;
         tend_in  = status.last && flush_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
         flush_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
         flush_ff <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BUF_DEPTH; i++) buf_ff[i] <= buf_in[i];
      cp_ff   <= cp_in;
      repl_ff <= repl_in;
      last_ff <= last_in;
      tend_ff <= tend_in;
   end

   assign out_valid       = valid_ff;
   assign out_code_point  = cp_ff;
   assign out_replaced    = repl_ff;
   assign out_last_of_run = last_ff;
   assign out_text_end    = tend_ff;

endmodule

`default_nettype wire

// File: sv/usd_ctrl.sv
// controller of the utf-8 decoder: accept one beat, then emit its results
// depends on usd_pkg; commands usd_datapath through usd_cmd_type
`default_nettype none

module usd_ctrl import usd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire usd_status_type status,
   output usd_cmd_type         cmd
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_DECODE = 1'b1;

   logic state_ff, state_in;

   assign in_ready = (state_ff == ST_IDLE);
   assign cmd.load = in_valid && in_ready;
   assign cmd.step = (state_ff == ST_DECODE) && status.emit && status.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (!status.emit) state_in = ST_IDLE;
            else if (status.out_free && status.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/utf8_stream_decoder.sv
// top level of the utf-8 stream decoder: controller plus datapath
// depends on usd_pkg, usd_if, usd_ctrl and usd_datapath
//
// usage
//  - req_chan carries one byte of text per beat, end_of_text on the final byte
//  - rsp_chan carries decoded code points; a beat can release zero to four of
//    them, the final one flagged with last_of_run (and text_end on a flush)
//  - invalid bytes give U+FFFD with replaced set and consume one byte only
// timing
//  - a byte is accepted while idle, then its results leave one per cycle
//    while the output register is free; the single decode unit handles one
//    sequence per cycle, and the next byte waits until the run ends
//  - the first result reaches rsp_chan through the output register
// reset
//  - synchronous, active high; empties the byte buffer and the output register
// stalls
//  - a waiting result sits in the output register; a stall on rsp_chan holds
//    the decode step but not the acceptance of the next byte once the run ends
`default_nettype none

module utf8_stream_decoder import usd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   usd_req_if.sink   req_chan,
   usd_rsp_if.source rsp_chan
);

   usd_cmd_type    cmd;
   usd_status_type status;

   // sequencing of accept and emit
   usd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .status   (status),
      .cmd      (cmd)
   );

   // byte buffer, decode and output register
   usd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_byte         (req_chan.data_byte),
      .in_end          (req_chan.end_of_text),
      .out_valid       (rsp_chan.valid),
      .out_ready       (rsp_chan.ready),
      .out_code_point  (rsp_chan.code_point),
      .out_replaced    (rsp_chan.replaced),
      .out_last_of_run (rsp_chan.last_of_run),
      .out_text_end    (rsp_chan.text_end)
   );

endmodule

`default_nettype wire
